/* rtl/bcpe_pkg.sv */
// shared types and constants of the cubic bezier point evaluator
`default_nettype none
package bcpe_pkg;
	localparam int CTRL_W = 10;
	localparam int STEP_W = 9;
	localparam int PY_W = 11;
	localparam int STEPS_LOG2 = 8;
	localparam int SCREEN_HEIGHT = 800;

	localparam int NUM_REGS = 8;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_FIRST_CTRL_X = 3'd2;
	localparam logic [IDX_W-1:0] REG_FIRST_CTRL_Y = 3'd3;
	localparam logic [IDX_W-1:0] REG_SECOND_CTRL_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_SECOND_CTRL_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_END_X = 3'd6;
	localparam logic [IDX_W-1:0] REG_END_Y = 3'd7;

	localparam logic [CTRL_W-1:0] RST_START_X = 10'd200;
	localparam logic [CTRL_W-1:0] RST_START_Y = 10'd400;
	localparam logic [CTRL_W-1:0] RST_FIRST_CTRL_X = 10'd400;
	localparam logic [CTRL_W-1:0] RST_FIRST_CTRL_Y = 10'd200;
	localparam logic [CTRL_W-1:0] RST_SECOND_CTRL_X = 10'd200;
	localparam logic [CTRL_W-1:0] RST_SECOND_CTRL_Y = 10'd200;
	localparam logic [CTRL_W-1:0] RST_END_X = 10'd400;
	localparam logic [CTRL_W-1:0] RST_END_Y = 10'd400;

	// power-basis coefficient and horner partial widths
	localparam int COEF_W = 14;
	localparam int NS_W = STEP_W + 1;
	localparam int H1_W = 24;
	localparam int H2_W = 33;
	localparam int H3_W = 43;
	localparam int RND_W = H3_W - 3 * STEPS_LOG2;
	localparam int SY_W = RND_W + 1;

	localparam int PIPE_DEPTH = 6;

	typedef struct packed {
		logic [CTRL_W-1:0] p0;
		logic [CTRL_W-1:0] p1;
		logic [CTRL_W-1:0] p2;
		logic [CTRL_W-1:0] p3;
	} ctrl_pts_t;
endpackage
`default_nettype wire

/* rtl/bcpe_axis.sv */
// five-stage horner evaluation and rounding of one curve axis
`default_nettype none
module bcpe_axis (
	input  wire logic                                clk,
	input  wire bcpe_pkg::ctrl_pts_t                 pts,
	input  wire logic [bcpe_pkg::STEP_W-1:0]         n,
	output logic signed [bcpe_pkg::RND_W-1:0]        rnd
);
	localparam int CW = bcpe_pkg::COEF_W;
	localparam int L2 = bcpe_pkg::STEPS_LOG2;

	logic signed [CW-1:0] e0, e1, e2, e3;
	logic signed [CW-1:0] ca, cb, cc;

	logic signed [CW-1:0] a_s1, b_s1, c_s1, c_s2;
	logic signed [CW-1:0] d_s1, d_s2, d_s3;
	logic signed [bcpe_pkg::NS_W-1:0] n_s1, n_s2, n_s3;
	logic signed [bcpe_pkg::H1_W-1:0] h1_s2;
	logic signed [bcpe_pkg::H2_W-1:0] h2_s3;
	logic signed [bcpe_pkg::H3_W-1:0] h3_s4;
	logic signed [bcpe_pkg::H3_W-1:0] rsum;

	always_comb begin
		e0 = $signed({{(CW-bcpe_pkg::CTRL_W){1'b0}}, pts.p0});
		e1 = $signed({{(CW-bcpe_pkg::CTRL_W){1'b0}}, pts.p1});
		e2 = $signed({{(CW-bcpe_pkg::CTRL_W){1'b0}}, pts.p2});
		e3 = $signed({{(CW-bcpe_pkg::CTRL_W){1'b0}}, pts.p3});
		ca = e3 - ((e2 <<< 1) + e2) + ((e1 <<< 1) + e1) - e0;
		cb = ((e2 <<< 1) + e2) - ((e1 <<< 2) + (e1 <<< 1)) + ((e0 <<< 1) + e0);
		cc = ((e1 <<< 1) + e1) - ((e0 <<< 1) + e0);
	end

	always_ff @(posedge clk) begin
		a_s1 <= ca;
		b_s1 <= cb;
		c_s1 <= cc;
		d_s1 <= e0;
		n_s1 <= $signed({1'b0, n});

		h1_s2 <= bcpe_pkg::H1_W'(a_s1) * bcpe_pkg::H1_W'(n_s1)
			+ (bcpe_pkg::H1_W'(b_s1) <<< L2);
		c_s2 <= c_s1;
		d_s2 <= d_s1;
		n_s2 <= n_s1;

		h2_s3 <= bcpe_pkg::H2_W'(h1_s2) * bcpe_pkg::H2_W'(n_s2)
			+ (bcpe_pkg::H2_W'(c_s2) <<< (2 * L2));
		d_s3 <= d_s2;
		n_s3 <= n_s2;

		h3_s4 <= bcpe_pkg::H3_W'(h2_s3) * bcpe_pkg::H3_W'(n_s3)
			+ (bcpe_pkg::H3_W'(d_s3) <<< (3 * L2));

		rnd <= rsum[bcpe_pkg::H3_W-1:3*L2];
	end

	// half up: add one half, then floor by arithmetic shift
	assign rsum = h3_s4 + (bcpe_pkg::H3_W'(1) <<< (3 * L2 - 1));
endmodule
`default_nettype wire

/* rtl/cubic_bezier_point_evaluator_top.sv */
// top level of the cubic bezier point evaluator
//
// usage: write the four control points (start, first control, second control,
// end; x and y each) through cfg_we / cfg_index / cfg_data, one 10-bit
// register per write, index 0..7 in that order. write only while no
// transaction is in flight.
// a transaction starts at a clock edge with start high and busy low;
// step_index gives t = step_index / 256. busy is high only in the first
// cycle after reset and low afterwards, so one point enters per cycle.
// done rises together with point_x, point_y and step_echo and stays high for
// one cycle; one result per cycle sustained. the depth is set by the three
// horner multiply stages plus the coefficient, rounding and clamp registers.
// the receiver cannot stall: each result is shown for exactly one cycle.
// reset loads the default curve and empties the pipeline.
`default_nettype none
module cubic_bezier_point_evaluator_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [bcpe_pkg::STEP_W-1:0]           step_index,
	output logic                                       done,
	output logic [bcpe_pkg::CTRL_W-1:0]                point_x,
	output logic signed [bcpe_pkg::PY_W-1:0]           point_y,
	output logic [bcpe_pkg::STEP_W-1:0]                step_echo,
	input  wire logic                                  cfg_we,
	input  wire logic [bcpe_pkg::IDX_W-1:0]            cfg_index,
	input  wire logic [bcpe_pkg::CTRL_W-1:0]           cfg_data
);
	localparam int D = bcpe_pkg::PIPE_DEPTH;
	localparam int RW = bcpe_pkg::RND_W;
	localparam int SW = bcpe_pkg::SY_W;

	logic [bcpe_pkg::CTRL_W-1:0] sx_q, sy_q, f1x_q, f1y_q, f2x_q, f2y_q, ex_q, ey_q;
	logic busy_q;
	logic [D-1:0] vld_q;
	logic [bcpe_pkg::STEP_W-1:0] step_q [D-1];
	bcpe_pkg::ctrl_pts_t pts_x, pts_y;
	logic signed [RW-1:0] rx_s5, ry_s5;
	logic signed [SW-1:0] scr_y;
	logic accept;

	assign accept = start && !busy_q;
	assign busy = busy_q;
	assign done = vld_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= bcpe_pkg::RST_START_X;
			sy_q <= bcpe_pkg::RST_START_Y;
			f1x_q <= bcpe_pkg::RST_FIRST_CTRL_X;
			f1y_q <= bcpe_pkg::RST_FIRST_CTRL_Y;
			f2x_q <= bcpe_pkg::RST_SECOND_CTRL_X;
			f2y_q <= bcpe_pkg::RST_SECOND_CTRL_Y;
			ex_q <= bcpe_pkg::RST_END_X;
			ey_q <= bcpe_pkg::RST_END_Y;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcpe_pkg::REG_START_X: sx_q <= cfg_data;
				bcpe_pkg::REG_START_Y: sy_q <= cfg_data;
				bcpe_pkg::REG_FIRST_CTRL_X: f1x_q <= cfg_data;
				bcpe_pkg::REG_FIRST_CTRL_Y: f1y_q <= cfg_data;
				bcpe_pkg::REG_SECOND_CTRL_X: f2x_q <= cfg_data;
				bcpe_pkg::REG_SECOND_CTRL_Y: f2y_q <= cfg_data;
				bcpe_pkg::REG_END_X: ex_q <= cfg_data;
				bcpe_pkg::REG_END_Y: ey_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_q <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q <= {vld_q[D-2:0], accept};
		end
	end

	// step index travels alongside the data
	always_ff @(posedge clk) begin
		step_q[0] <= step_index;
		for (int i = 1; i < D - 1; i++) begin
			step_q[i] <= step_q[i-1];
		end
		step_echo <= step_q[D-2];
	end

	always_comb begin
		pts_x.p0 = sx_q;
		pts_x.p1 = f1x_q;
		pts_x.p2 = f2x_q;
		pts_x.p3 = ex_q;
		pts_y.p0 = sy_q;
		pts_y.p1 = f1y_q;
		pts_y.p2 = f2y_q;
		pts_y.p3 = ey_q;
	end

	bcpe_axis u_axis_x (
		.clk (clk),
		.pts (pts_x),
		.n   (step_index),
		.rnd (rx_s5)
	);

	bcpe_axis u_axis_y (
		.clk (clk),
		.pts (pts_y),
		.n   (step_index),
		.rnd (ry_s5)
	);

	assign scr_y = SW'(bcpe_pkg::SCREEN_HEIGHT) - SW'(ry_s5);

	// saturate to the screen fields
	always_ff @(posedge clk) begin
		if (rx_s5 < 0) begin
			point_x <= '0;
		end else if (rx_s5 > RW'((1 << bcpe_pkg::CTRL_W) - 1)) begin
			point_x <= '1;
		end else begin
			point_x <= rx_s5[bcpe_pkg::CTRL_W-1:0];
		end
		if (scr_y < -SW'(1 << (bcpe_pkg::PY_W - 1))) begin
			point_y <= {1'b1, {(bcpe_pkg::PY_W-1){1'b0}}};
		end else if (scr_y > SW'((1 << (bcpe_pkg::PY_W - 1)) - 1)) begin
			point_y <= {1'b0, {(bcpe_pkg::PY_W-1){1'b1}}};
		end else begin
			point_y <= scr_y[bcpe_pkg::PY_W-1:0];
		end
	end

	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after leaving reset");

	a_first_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !vld_q[0])
		else $error("transaction entered while busy");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, D))
		else $error("result without a matching transaction");

	a_echo_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> step_echo == $past(step_index, D))
		else $error("step echo out of line with its transaction");
endmodule
`default_nettype wire

/* tb/bezier_point_check.sv */
// checker for the bezier point evaluator: shadows the curve registers, predicts and compares points
`timescale 1ns / 1ps
`default_nettype none
module bezier_point_check
	import bcpe_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     busy,
	input  wire logic [STEP_W-1:0]        step_index,
	input  wire logic                     cfg_we,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [CTRL_W-1:0]        cfg_data,
	input  wire logic                     done,
	input  wire logic [CTRL_W-1:0]        point_x,
	input  wire logic signed [PY_W-1:0]   point_y,
	input  wire logic [STEP_W-1:0]        step_echo,
	output int                            errors,
	output int                            outstanding
);
	typedef struct packed {
		logic [CTRL_W-1:0]        x;
		logic signed [PY_W-1:0]   y;
		logic [STEP_W-1:0]        n;
	} screen_point_t;

	logic [CTRL_W-1:0] ctrl_regs [NUM_REGS];
	screen_point_t expected_points [$];
	screen_point_t want;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	// exact rational evaluation, rounded half up: floor((2 S + steps^3) / (2 steps^3))
	function automatic longint round_axis(input longint p0, input longint p1,
			input longint p2, input longint p3, input longint n);
		longint steps;
		longint ca;
		longint cb;
		longint cc;
		longint num;
		steps = longint'(1) << STEPS_LOG2;
		ca = p3 - 3 * p2 + 3 * p1 - p0;
		cb = 3 * p2 - 6 * p1 + 3 * p0;
		cc = 3 * p1 - 3 * p0;
		num = ca * n * n * n + cb * n * n * steps + cc * n * steps * steps
			+ p0 * steps * steps * steps;
		return (2 * num + steps * steps * steps) >>> (3 * STEPS_LOG2 + 1);
	endfunction

	function automatic screen_point_t project_point(input logic [STEP_W-1:0] n);
		longint cx;
		longint cy;
		longint sy;
		screen_point_t pt;
		cx = round_axis(longint'(ctrl_regs[REG_START_X]),
			longint'(ctrl_regs[REG_FIRST_CTRL_X]),
			longint'(ctrl_regs[REG_SECOND_CTRL_X]),
			longint'(ctrl_regs[REG_END_X]), longint'(n));
		cy = round_axis(longint'(ctrl_regs[REG_START_Y]),
			longint'(ctrl_regs[REG_FIRST_CTRL_Y]),
			longint'(ctrl_regs[REG_SECOND_CTRL_Y]),
			longint'(ctrl_regs[REG_END_Y]), longint'(n));
		sy = SCREEN_HEIGHT - cy;
		if (cx < 0) cx = 0;
		if (cx > 1023) cx = 1023;
		if (sy < -1024) sy = -1024;
		if (sy > 1023) sy = 1023;
		pt.x = cx[CTRL_W-1:0];
		pt.y = sy[PY_W-1:0];
		pt.n = n;
		return pt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_regs[REG_START_X] <= RST_START_X;
			ctrl_regs[REG_START_Y] <= RST_START_Y;
			ctrl_regs[REG_FIRST_CTRL_X] <= RST_FIRST_CTRL_X;
			ctrl_regs[REG_FIRST_CTRL_Y] <= RST_FIRST_CTRL_Y;
			ctrl_regs[REG_SECOND_CTRL_X] <= RST_SECOND_CTRL_X;
			ctrl_regs[REG_SECOND_CTRL_Y] <= RST_SECOND_CTRL_Y;
			ctrl_regs[REG_END_X] <= RST_END_X;
			ctrl_regs[REG_END_Y] <= RST_END_Y;
			expected_points.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				ctrl_regs[cfg_index] <= cfg_data;
			if (start && !busy)
				expected_points.push_back(project_point(step_index));
			if (done) begin
				if (expected_points.size() == 0) begin
					$error("point transaction with nothing expected: x %0d y %0d step %0d",
						point_x, point_y, step_echo);
					errors++;
				end else begin
					want = expected_points.pop_front();
					if (point_x !== want.x) begin
						$error("point_x mismatch: expected %0d, got %0d", want.x, point_x);
						errors++;
					end
					if (point_y !== want.y) begin
						$error("point_y mismatch: expected %0d, got %0d", want.y, point_y);
						errors++;
					end
					if (step_echo !== want.n) begin
						$error("step_echo mismatch: expected %0d, got %0d", want.n, step_echo);
						errors++;
					end
				end
			end
			outstanding <= expected_points.size();
		end
	end
endmodule
`default_nettype wire

/* tb/cubic_bezier_point_evaluator_top_test.sv */
// top of the bezier point evaluator testbench: clock, reset, curve setup and step stimulus
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_point_evaluator_top_test;
	import bcpe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [STEP_W-1:0] step_index = '0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CTRL_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	logic [CTRL_W-1:0] point_x;
	logic signed [PY_W-1:0] point_y;
	logic [STEP_W-1:0] step_echo;
	int errors;
	int outstanding;
	int cycles = 0;
	logic [CTRL_W-1:0] curve [NUM_REGS];

	always #4 clk = ~clk;

	cubic_bezier_point_evaluator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.step_index(step_index),
		.done(done),
		.point_x(point_x),
		.point_y(point_y),
		.step_echo(step_echo),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bezier_point_check point_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.step_index(step_index),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.point_x(point_x),
		.point_y(point_y),
		.step_echo(step_echo),
		.errors(errors),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cubic_bezier_point_evaluator_top verification failed");
			$finish;
		end
	end

	task automatic send_point(input logic [STEP_W-1:0] n);
		start <= 1'b1;
		step_index <= n;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_steps(input int steps [$]);
		foreach (steps[k])
			send_point(STEP_W'(steps[k]));
	endtask

	// drain the pipeline before touching the curve
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic load_curve();
		for (int i = REG_START_X; i <= REG_END_Y; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= curve[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic set_curve(input int x0, input int y0, input int x1, input int y1,
			input int x2, input int y2, input int x3, input int y3);
		curve[REG_START_X] = CTRL_W'(x0);
		curve[REG_START_Y] = CTRL_W'(y0);
		curve[REG_FIRST_CTRL_X] = CTRL_W'(x1);
		curve[REG_FIRST_CTRL_Y] = CTRL_W'(y1);
		curve[REG_SECOND_CTRL_X] = CTRL_W'(x2);
		curve[REG_SECOND_CTRL_Y] = CTRL_W'(y2);
		curve[REG_END_X] = CTRL_W'(x3);
		curve[REG_END_Y] = CTRL_W'(y3);
		load_curve();
	endtask

	function automatic logic [CTRL_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CTRL_W'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic random_points(input int count);
		int burst;
		burst = 0;
		for (int k = 0; k < count; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			end
			if ($urandom_range(0, 6) == 0)
				send_point(STEP_W'($urandom_range(257, 511)));
			else
				send_point(STEP_W'($urandom_range(0, 256)));
			burst--;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default curve, including steps past the curve end
		send_steps('{0, 1, 128, 255, 256, 257, 300, 511});
		settle();
		set_curve(0, 0, 0, 0, 0, 0, 0, 0);
		send_steps('{0, 256, 511});
		settle();
		set_curve(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
		send_steps('{0, 100, 256, 511});
		settle();
		// zigzag control points drive extrapolation into saturation both ways
		set_curve(0, 1023, 1023, 0, 0, 1023, 1023, 0);
		send_steps('{511, 400, 300, 256, 0});
		settle();
		set_curve(1023, 0, 0, 1023, 1023, 0, 0, 1023);
		send_steps('{511, 400, 300});
		settle();

		for (int phase = 0; phase < 6; phase++) begin
			set_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
				pick_coord(), pick_coord(), pick_coord(), pick_coord());
			random_points(150);
			settle();
		end

		if (errors == 0)
			$display("cubic_bezier_point_evaluator_top verification clean");
		else
			$display("cubic_bezier_point_evaluator_top verification failed");
		$finish;
	end
endmodule
`default_nettype wire
